// File: rtl/iws_pkg.sv
// Shared types, constants and the decay table for the inertial wheel scroll block.
package iws_pkg;

  localparam int VEL_W  = 26;
  localparam int MAG_W  = 24;
  localparam int QUO_W  = 18;
  localparam int ELAP_W = 8;
  localparam int REM_W  = 18;
  localparam int DIST_W = 32;
  localparam int CFG_W  = 16;
  localparam int PIX_W  = 14;
  localparam int DEC_W  = 17;

  localparam logic CMD_WHEEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    CFG_IMPULSE_SPEED,
    CFG_MAX_SPEED,
    CFG_STOP_SPEED
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] IMPULSE_RESET = 16'd2100;
  localparam logic [CFG_W-1:0] MAX_RESET     = 16'd4200;
  localparam logic [CFG_W-1:0] STOP_RESET    = 16'd8;

  // exact floor(m / 125) for m < 2^24
  localparam logic [24:0] RECIP_A = 25'd17179870;
  localparam int          SHIFT_A = 31;
  // exact floor(t / 125) for t < 2^20
  localparam logic [20:0] RECIP_B = 21'd1073742;
  localparam int          SHIFT_B = 27;

  localparam logic [12:0] PIX_LIMIT = 13'd4096;

  localparam logic [95:0] DECAY_Q32 = 96'd4260744631;

  typedef logic [DEC_W-1:0] decay_tab_t [256];

  typedef struct packed {
    logic [CFG_W-1:0] impulse_speed;
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] stop_speed;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [QUO_W-1:0]  quo;
    logic [ELAP_W-1:0] elap;
    logic              dist_en;
    logic              clr;
    logic              moving;
  } stage1_t;

  typedef struct packed {
    logic               neg;
    logic [DIST_W-1:0]  span;
    logic               dist_en;
    logic               clr;
    logic               moving;
  } dist_t;

  // exp(-8t) per millisecond in Q16, built at elaboration
  function automatic decay_tab_t decay_table();
    decay_tab_t  tab;
    logic [95:0] e;
    e = 96'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      tab[k] = DEC_W'((e + 96'h8000) >> 16);
      e = (e * DECAY_Q32 + 96'h8000_0000) >> 32;
    end
    return tab;
  endfunction

endpackage

// File: rtl/iws_if.sv
// Item channels of the inertial wheel scroll block.
interface iws_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [7:0] wheel_steps;
  logic [31:0]       now_ms;
  logic              blocked;
  logic              pointer_pressed;

  modport source(output valid, cmd, wheel_steps, now_ms, blocked, pointer_pressed,
                 input ready);
  modport sink(input valid, cmd, wheel_steps, now_ms, blocked, pointer_pressed,
               output ready);
endinterface

interface iws_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] scroll_pixels;
  logic               scroll_valid;
  logic               moving;

  modport source(output valid, scroll_pixels, scroll_valid, moving, input ready);
  modport sink(input valid, scroll_pixels, scroll_valid, moving, output ready);
endinterface

// File: rtl/iws_motion.sv
// Velocity and time state update, decay and first step of the distance division.
module iws_motion #(
  parameter int TIME_BITS   = 32,
  parameter int MAX_STEP_MS = 50
) (
  input  logic                clk,
  input  logic                rst,
  iws_in_if.sink              wheel,
  input  iws_pkg::cfg_t       cfg,
  output logic                s1_valid,
  output iws_pkg::stage1_t    s1,
  input  logic                s1_ready
);

  localparam iws_pkg::decay_tab_t DECAY_TAB = iws_pkg::decay_table();

  logic signed [iws_pkg::VEL_W-1:0] velocity, velocity_next;
  logic [TIME_BITS-1:0]             last_time, last_time_next;
  logic                             time_known, time_known_next;

  logic [TIME_BITS-1:0]             now_t, base_t, diff;
  logic [iws_pkg::ELAP_W-1:0]       elap;
  logic                             accept;

  logic signed [24:0]               wprod;
  logic signed [32:0]               wimp;
  logic signed [33:0]               wsum, wlim;
  logic signed [iws_pkg::VEL_W-1:0] wvel;

  logic [iws_pkg::VEL_W-1:0]        vabs;
  logic [iws_pkg::MAG_W-1:0]        mag, vq;
  logic [40:0]                      dprod;
  logic signed [iws_pkg::VEL_W-1:0] vdec;
  logic                             stop;
  logic [48:0]                      qprod;
  logic                             dist_en, clr;

  generate
    if (TIME_BITS > 32) begin : g_wide
      assign now_t = {{(TIME_BITS-32){1'b0}}, wheel.now_ms};
    end else if (TIME_BITS == 32) begin : g_same
      assign now_t = wheel.now_ms;
    end else begin : g_narrow
      assign now_t = wheel.now_ms[TIME_BITS-1:0];
    end
  endgenerate

  assign base_t = time_known ? last_time : now_t;
  assign diff   = now_t - base_t;
  assign elap   = (diff > TIME_BITS'(MAX_STEP_MS)) ? iws_pkg::ELAP_W'(MAX_STEP_MS)
                                                   : diff[iws_pkg::ELAP_W-1:0];

  // wheel impulse with clamp
  assign wprod = wheel.wheel_steps * $signed({1'b0, cfg.impulse_speed});
  assign wimp  = {wprod, 8'd0};
  assign wsum  = 34'(velocity) + 34'(wimp);
  assign wlim  = $signed({10'd0, cfg.max_speed, 8'd0});
  always_comb begin
    if (wsum > wlim) begin
      wvel = iws_pkg::VEL_W'(wlim);
    end else if (wsum < -wlim) begin
      wvel = iws_pkg::VEL_W'(-wlim);
    end else begin
      wvel = iws_pkg::VEL_W'(wsum);
    end
  end

  // decay, rounded half away from zero
  assign vabs  = velocity[iws_pkg::VEL_W-1] ? iws_pkg::VEL_W'(-velocity)
                                            : iws_pkg::VEL_W'(velocity);
  assign mag   = vabs[iws_pkg::MAG_W-1:0];
  assign dprod = 41'(mag) * 41'(DECAY_TAB[elap]);
  assign vq    = iws_pkg::MAG_W'((dprod + 41'd32768) >> 16);
  assign vdec  = velocity[iws_pkg::VEL_W-1] ? -$signed({2'b00, vq}) : $signed({2'b00, vq});
  assign stop  = vq < {cfg.stop_speed, 8'd0};

  // mag / 125 for the distance path
  assign qprod = 49'(mag) * 49'(iws_pkg::RECIP_A);

  always_comb begin
    velocity_next   = velocity;
    last_time_next  = last_time;
    time_known_next = time_known;
    dist_en         = 1'b0;
    clr             = 1'b0;
    if (wheel.cmd == iws_pkg::CMD_WHEEL) begin
      if (wheel.wheel_steps != 8'sd0 && !wheel.blocked) begin
        velocity_next = wvel;
        if (!time_known) begin
          last_time_next  = now_t;
          time_known_next = 1'b1;
        end
      end
    end else if (wheel.blocked || wheel.pointer_pressed) begin
      velocity_next   = '0;
      last_time_next  = '0;
      time_known_next = 1'b0;
      clr             = 1'b1;
    end else begin
      last_time_next  = now_t;
      time_known_next = 1'b1;
      if (velocity != '0 && elap != '0) begin
        dist_en       = 1'b1;
        velocity_next = vdec;
        if (stop) begin
          velocity_next   = '0;
          last_time_next  = '0;
          time_known_next = 1'b0;
          clr             = 1'b1;
        end
      end
    end
  end

  assign wheel.ready = !s1_valid || s1_ready;
  assign accept      = wheel.valid && wheel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity   <= '0;
      last_time  <= '0;
      time_known <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        velocity   <= velocity_next;
        last_time  <= last_time_next;
        time_known <= time_known_next;
      end
      if (wheel.ready) begin
        s1_valid <= wheel.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.neg     <= velocity[iws_pkg::VEL_W-1];
      s1.mag     <= mag;
      s1.quo     <= qprod[48:iws_pkg::SHIFT_A];
      s1.elap    <= elap;
      s1.dist_en <= dist_en;
      s1.clr     <= clr;
      s1.moving  <= velocity_next != '0;
    end
  end

endmodule

// File: rtl/iws_dist.sv
// Two-stage pipeline giving round(|v| * elapsed * 256 / 1000) in Q16 pixels.
module iws_dist (
  input  logic             clk,
  input  logic             rst,
  input  logic             s1_valid,
  input  iws_pkg::stage1_t s1,
  output logic             s1_ready,
  output logic             s3_valid,
  input  logic             s3_ready,
  output iws_pkg::dist_t   s3
);

  // stage 2: mag = 125 * quo + rest, products with elapsed
  logic                       s2_valid, s2_ready;
  logic                       s2_neg, s2_dist_en, s2_clr, s2_moving;
  logic [25:0]                s2_ae;
  logic [14:0]                s2_be;
  logic [24:0]                q125;
  logic [6:0]                 rest;

  assign q125 = 25'(s1.quo) * 25'd125;
  assign rest = 7'(s1.mag - q125[iws_pkg::MAG_W-1:0]);

  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_neg     <= s1.neg;
      s2_dist_en <= s1.dist_en;
      s2_clr     <= s1.clr;
      s2_moving  <= s1.moving;
      s2_ae      <= 26'(s1.quo) * 26'(s1.elap);
      s2_be      <= 15'(rest) * 15'(s1.elap);
    end
  end

  // stage 3: 32*ae + floor((32*be + 62) / 125)
  logic [19:0] tail;
  logic [40:0] tprod;
  logic [13:0] qlo;

  assign tail  = {s2_be, 5'd0} + 20'd62;
  assign tprod = 41'(tail) * 41'(iws_pkg::RECIP_B);
  assign qlo   = tprod[40:iws_pkg::SHIFT_B];

  assign s2_ready = !s3_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      s3.neg     <= s2_neg;
      s3.span    <= {1'b0, s2_ae, 5'd0} + iws_pkg::DIST_W'(qlo);
      s3.dist_en <= s2_dist_en;
      s3.clr     <= s2_clr;
      s3.moving  <= s2_moving;
    end
  end

endmodule

// File: rtl/iws_out.sv
// Sub-pixel remainder accumulation, pixel rounding and the result register.
module iws_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            s3_valid,
  input  iws_pkg::dist_t  s3,
  output logic            s3_ready,
  iws_out_if.source       scroll
);

  logic signed [iws_pkg::REM_W-1:0] remainder, remainder_next;
  logic signed [33:0]               total;
  logic [32:0]                      dabs;
  logic [17:0]                      pq;
  logic [1:0]                       pq_lo;
  logic [12:0]                      sat;
  logic signed [iws_pkg::PIX_W-1:0] pix;
  logic                             load;

  assign total = s3.neg ? 34'(remainder) - $signed({2'b00, s3.span})
                        : 34'(remainder) + $signed({2'b00, s3.span});
  assign dabs  = total[33] ? 33'(-total) : 33'(total);
  assign pq    = 18'((34'(dabs) + 34'd32768) >> 16);
  assign pq_lo = total[33] ? 2'(-pq) : pq[1:0];
  assign remainder_next = $signed(total[iws_pkg::REM_W-1:0] - {pq_lo, 16'd0});
  assign sat   = (pq > 18'(iws_pkg::PIX_LIMIT)) ? iws_pkg::PIX_LIMIT : pq[12:0];
  assign pix   = total[33] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});

  assign s3_ready = !scroll.valid || scroll.ready;
  assign load     = s3_ready && s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll.valid <= 1'b0;
      remainder    <= '0;
    end else begin
      if (s3_ready) begin
        scroll.valid <= s3_valid;
      end
      if (load) begin
        if (s3.clr) begin
          remainder <= '0;
        end else if (s3.dist_en) begin
          remainder <= remainder_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scroll.scroll_pixels <= s3.dist_en ? pix : '0;
      scroll.scroll_valid  <= s3.dist_en && pq != '0;
      scroll.moving        <= s3.moving;
    end
  end

endmodule

// File: rtl/inertial_wheel_scroll.sv
// Inertial wheel scroll: wheel items push a decaying velocity, tick items
// turn it into whole scroll pixels. One item is accepted every clock cycle
// while the output is taken; each result passes the stage-1, stage-2,
// stage-3 and output registers. These four registers hold up to four items
// while results wait at the output, after which the input stalls. The rate
// of one item a cycle is set by the velocity and timestamp update, which is
// registered on acceptance; distance division and sub-pixel remainder run
// in a following pipeline. No clearing pass follows reset.
module inertial_wheel_scroll #(
  parameter int MAX_STEP_MS = 50,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  iws_in_if.sink      wheel,
  iws_out_if.source   scroll
);

  iws_pkg::cfg_t    cfg;
  iws_pkg::stage1_t s1;
  iws_pkg::dist_t   s3;
  logic             s1_valid, s1_ready;
  logic             s3_valid, s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.impulse_speed <= iws_pkg::IMPULSE_RESET;
      cfg.max_speed     <= iws_pkg::MAX_RESET;
      cfg.stop_speed    <= iws_pkg::STOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iws_pkg::CFG_IMPULSE_SPEED: cfg.impulse_speed <= cfg_data;
        iws_pkg::CFG_MAX_SPEED:     cfg.max_speed     <= cfg_data;
        iws_pkg::CFG_STOP_SPEED:    cfg.stop_speed    <= cfg_data;
        default: ;
      endcase
    end
  end

  iws_motion #(
    .TIME_BITS   (TIME_BITS),
    .MAX_STEP_MS (MAX_STEP_MS)
  ) u_motion (
    .clk      (clk),
    .rst      (rst),
    .wheel    (wheel),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready)
  );

  iws_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  iws_out u_out (
    .clk      (clk),
    .rst      (rst),
    .s3_valid (s3_valid),
    .s3       (s3),
    .s3_ready (s3_ready),
    .scroll   (scroll)
  );

endmodule
